// ----- rtl/bptc_pkg.sv -----
// ----------------------------------------------------------------------------
// bptc_pkg
// Types, register codes and helper functions for the barometer compensation
// pipeline.
// ----------------------------------------------------------------------------
package bptc_pkg;

   localparam int DIV_STEPS = 32;

   typedef enum logic [2:0] {
      REG_OVERSAMPLING = 3'd0,
      REG_CAL_AC1_AC2  = 3'd1,
      REG_CAL_AC3_AC4  = 3'd2,
      REG_CAL_AC5_AC6  = 3'd3,
      REG_CAL_B1_B2    = 3'd4,
      REG_CAL_MC_MD    = 3'd5
   } reg_index_type;

   // one slot of a restoring divider pipeline plus the values carried alongside
   typedef struct packed {
      logic [31:0] rem;
      logic [31:0] quo;
      logic [31:0] dvs;
      logic        flag;
      logic [31:0] keep;
      logic [23:0] up;
      logic        fault;
   } div_type;

   function automatic logic [31:0] sx16(logic [15:0] x);
      sx16 = {{16{x[15]}}, x};
   endfunction

   function automatic logic [31:0] asr(logic [31:0] x, logic [4:0] n);
      asr = 32'($signed(x) >>> n);
   endfunction

   // one quotient bit: shift in the next dividend bit, subtract where it fits
   function automatic div_type div_step(div_type d);
      div_type     r;
      logic [32:0] t;
      logic [32:0] s;
      r = d;
      t = {d.rem, d.quo[31]};
      s = t - {1'b0, d.dvs};
      if (!s[32]) begin
         r.rem = s[31:0];
         r.quo = {d.quo[30:0], 1'b1};
      end else begin
         r.rem = t[31:0];
         r.quo = {d.quo[30:0], 1'b0};
      end
      div_step = r;
   endfunction

endpackage

// ----- rtl/baro_pressure_temp_compensation_top.sv -----
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation_top
// Barometer temperature and pressure compensation, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one request: raw temperature word and the three raw
//   pressure bytes. rsp_* returns temperature in 0.1 degC, pressure in Pa
//   and a fault flag (set, with zero results, when a divisor is zero).
//   csr_* is the register port for oversampling and the calibration pairs;
//   write it only while no request is in flight.
// Two restoring dividers of 32 one-bit stages each sit in the pipeline.
// Throughput: one request per cycle, unless a stalled output stage holds it.
// Reset clears all valid bits and the configuration registers to zero.
// When rsp_tready is low with a result waiting, the whole pipeline holds
//   and req_tready drops; nothing is lost or repeated, and req_tready stays
//   high whenever the output stage is empty; bubbles are not squeezed out.
// ----------------------------------------------------------------------------
module baro_pressure_temp_compensation_top
   import bptc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // raw_temperature[15:0], raw_pressure_bytes[39:16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // temperature_tenths[15:0], pressure_pa[47:16]
   output logic        rsp_tuser,   // divide_fault
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // ---------------- configuration ----------------
   logic [1:0]  oss_ff;
   logic [31:0] ac12_ff, ac34_ff, ac56_ff, b12_ff, mcmd_ff;
   logic        wr;
   reg_index_type idx;

   assign csr_pready = 1'b1;
   assign wr  = csr_psel & csr_penable & csr_pwrite;
   assign idx = reg_index_type'(csr_paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         oss_ff  <= '0;
         ac12_ff <= '0;
         ac34_ff <= '0;
         ac56_ff <= '0;
         b12_ff  <= '0;
         mcmd_ff <= '0;
      end else if (wr) begin
         unique case (idx)
            REG_OVERSAMPLING: oss_ff  <= csr_pwdata[1:0];
            REG_CAL_AC1_AC2:  ac12_ff <= csr_pwdata;
            REG_CAL_AC3_AC4:  ac34_ff <= csr_pwdata;
            REG_CAL_AC5_AC6:  ac56_ff <= csr_pwdata;
            REG_CAL_B1_B2:    b12_ff  <= csr_pwdata;
            REG_CAL_MC_MD:    mcmd_ff <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_OVERSAMPLING: csr_prdata = {30'd0, oss_ff};
         REG_CAL_AC1_AC2:  csr_prdata = ac12_ff;
         REG_CAL_AC3_AC4:  csr_prdata = ac34_ff;
         REG_CAL_AC5_AC6:  csr_prdata = ac56_ff;
         REG_CAL_B1_B2:    csr_prdata = b12_ff;
         REG_CAL_MC_MD:    csr_prdata = mcmd_ff;
         default:          csr_prdata = '0;
      endcase
   end

   logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
   assign ac1 = sx16(ac12_ff[31:16]);
   assign ac2 = sx16(ac12_ff[15:0]);
   assign ac3 = sx16(ac34_ff[31:16]);
   assign ac4 = {16'd0, ac34_ff[15:0]};
   assign ac5 = {16'd0, ac56_ff[31:16]};
   assign ac6 = {16'd0, ac56_ff[15:0]};
   assign b1  = sx16(b12_ff[31:16]);
   assign b2  = sx16(b12_ff[15:0]);
   assign mc  = sx16(mcmd_ff[31:16]);
   assign md  = sx16(mcmd_ff[15:0]);

   // ---------------- pipeline ----------------
   logic en;
   logic rsp_valid_ff;
   assign en         = ~rsp_valid_ff | rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = rsp_valid_ff;

   // stage 1: capture request, align pressure
   logic        v1_ff;
   logic [15:0] ut1_ff;
   logic [23:0] up1_ff;
   // stage 2: temperature offset product
   logic        v2_ff;
   logic [31:0] x1a2_ff;
   logic [23:0] up2_ff;
   // temperature divider
   logic    tv_ff [DIV_STEPS+1];
   div_type td_ff [DIV_STEPS+1];
   // stage 4: b5, b6
   logic        v4_ff, f4_ff;
   logic [31:0] b5_4_ff, b6_4_ff;
   logic [23:0] up4_ff;
   // stage 5: products of b6
   logic        v5_ff, f5_ff;
   logic [31:0] b5_5_ff, sqp5_ff, ac2b6_5_ff, ac3b6_5_ff;
   logic [23:0] up5_ff;
   // stage 6: products of sq and scaled b6 products
   logic        v6_ff, f6_ff;
   logic [31:0] b5_6_ff, b2sq6_ff, b1sq6_ff, x2a6_ff, x1c6_ff;
   logic [23:0] up6_ff;
   // stage 7: b3 and b4 operand
   logic        v7_ff, f7_ff;
   logic [31:0] b5_7_ff, b3_7_ff, x3p7_ff;
   logic [23:0] up7_ff;
   // stage 8: b4 and b7 products
   logic        v8_ff, f8_ff;
   logic [31:0] b5_8_ff, b4p8_ff, b7_8_ff;
   // pressure divider
   logic    pv_ff [DIV_STEPS+1];
   div_type pd_ff [DIV_STEPS+1];
   // stage 10: pressure correction products
   logic        v10_ff, f10_ff;
   logic [31:0] b5_10_ff, p10_ff, x1m10_ff, x2m10_ff;
   // stage 11: second product
   logic        v11_ff, f11_ff;
   logic [31:0] b5_11_ff, p11_ff, x1n11_ff, x2_11_ff;
   // output
   logic [15:0] temp_ff;
   logic [31:0] pres_ff;
   logic        fault_ff;

   assign rsp_tdata = {pres_ff, temp_ff};
   assign rsp_tuser = fault_ff;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v4_ff <= 1'b0; v5_ff <= 1'b0;
         v6_ff <= 1'b0; v7_ff <= 1'b0; v8_ff <= 1'b0; v10_ff <= 1'b0;
         v11_ff <= 1'b0; rsp_valid_ff <= 1'b0;
         for (int k = 0; k <= DIV_STEPS; k++) begin
            tv_ff[k] <= 1'b0;
            pv_ff[k] <= 1'b0;
         end
      end else if (en) begin
         v1_ff <= req_tvalid;
         v2_ff <= v1_ff;
         tv_ff[0] <= v2_ff;
         for (int k = 1; k <= DIV_STEPS; k++) tv_ff[k] <= tv_ff[k-1];
         v4_ff <= tv_ff[DIV_STEPS];
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
         v8_ff <= v7_ff;
         pv_ff[0] <= v8_ff;
         for (int k = 1; k <= DIV_STEPS; k++) pv_ff[k] <= pv_ff[k-1];
         v10_ff <= pv_ff[DIV_STEPS];
         v11_ff <= v10_ff;
         rsp_valid_ff <= v11_ff;
      end
   end

   // stage comb values
   logic [31:0] div_t, num_t, x2_t, b5_in, x3_7, b3_7_in, x3b_7, b4_9, b7_9;
   logic [31:0] p_10, a_10, pfin;
   logic [31:0] tsh;
   div_type     tset, pset;

   always_comb begin
      div_t = x1a2_ff + md;
      num_t = {mc[20:0], 11'd0};
      tset.rem   = '0;
      tset.quo   = num_t[31] ? 32'(-num_t) : num_t;
      tset.dvs   = div_t[31] ? 32'(-div_t) : div_t;
      tset.flag  = num_t[31] ^ div_t[31];
      tset.keep  = x1a2_ff;
      tset.up    = up2_ff;
      tset.fault = (div_t == 32'd0);

      x2_t  = td_ff[DIV_STEPS].flag ? 32'(-td_ff[DIV_STEPS].quo) : td_ff[DIV_STEPS].quo;
      b5_in = td_ff[DIV_STEPS].keep + x2_t;

      x3_7    = asr(b2sq6_ff, 5'd11) + x2a6_ff;
      b3_7_in = asr(32'(((32'(ac1 << 2) + x3_7) << oss_ff) + 32'd2), 5'd2);
      x3b_7   = asr(x1c6_ff + asr(b1sq6_ff, 5'd16) + 32'd2, 5'd2);

      b4_9 = b4p8_ff >> 15;
      b7_9 = b7_8_ff;
      pset.rem   = '0;
      pset.flag  = ~b7_9[31];
      pset.quo   = b7_9[31] ? b7_9 : {b7_9[30:0], 1'b0};
      pset.dvs   = b4_9;
      pset.keep  = b5_8_ff;
      pset.up    = '0;
      pset.fault = f8_ff | (b4_9 == 32'd0);

      p_10 = pd_ff[DIV_STEPS].flag ? pd_ff[DIV_STEPS].quo
                                   : {pd_ff[DIV_STEPS].quo[30:0], 1'b0};
      a_10 = asr(p_10, 5'd8);

      pfin = p11_ff + asr(asr(x1n11_ff, 5'd16) + x2_11_ff + 32'd3791, 5'd4);
      tsh  = asr(b5_11_ff + 32'd8, 5'd4);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ut1_ff  <= req_tdata[15:0];
         up1_ff  <= req_tdata[39:16] >> (4'd8 - {2'd0, oss_ff});

         x1a2_ff <= asr(32'(({16'd0, ut1_ff} - ac6) * ac5), 5'd15);
         up2_ff  <= up1_ff;

         td_ff[0] <= tset;
         for (int k = 1; k <= DIV_STEPS; k++) td_ff[k] <= div_step(td_ff[k-1]);

         b5_4_ff <= b5_in;
         b6_4_ff <= b5_in - 32'd4000;
         up4_ff  <= td_ff[DIV_STEPS].up;
         f4_ff   <= td_ff[DIV_STEPS].fault;

         sqp5_ff    <= 32'(b6_4_ff * b6_4_ff);
         ac2b6_5_ff <= 32'(ac2 * b6_4_ff);
         ac3b6_5_ff <= 32'(ac3 * b6_4_ff);
         b5_5_ff <= b5_4_ff; up5_ff <= up4_ff; f5_ff <= f4_ff;

         b2sq6_ff <= 32'(b2 * asr(sqp5_ff, 5'd12));
         b1sq6_ff <= 32'(b1 * asr(sqp5_ff, 5'd12));
         x2a6_ff  <= asr(ac2b6_5_ff, 5'd11);
         x1c6_ff  <= asr(ac3b6_5_ff, 5'd13);
         b5_6_ff <= b5_5_ff; up6_ff <= up5_ff; f6_ff <= f5_ff;

         b3_7_ff <= b3_7_in;
         x3p7_ff <= x3b_7 + 32'd32768;
         b5_7_ff <= b5_6_ff; up7_ff <= up6_ff; f7_ff <= f6_ff;

         b4p8_ff <= 32'(ac4 * x3p7_ff);
         b7_8_ff <= 32'(({8'd0, up7_ff} - b3_7_ff) * (32'd50000 >> oss_ff));
         b5_8_ff <= b5_7_ff; f8_ff <= f7_ff;

         pd_ff[0] <= pset;
         for (int k = 1; k <= DIV_STEPS; k++) pd_ff[k] <= div_step(pd_ff[k-1]);

         p10_ff   <= p_10;
         x1m10_ff <= 32'(a_10 * a_10);
         x2m10_ff <= 32'(p_10 * 32'hFFFF_E343);
         b5_10_ff <= pd_ff[DIV_STEPS].keep;
         f10_ff   <= pd_ff[DIV_STEPS].fault;

         x1n11_ff <= 32'(x1m10_ff * 32'd3038);
         x2_11_ff <= asr(x2m10_ff, 5'd16);
         p11_ff   <= p10_ff;
         b5_11_ff <= b5_10_ff;
         f11_ff   <= f10_ff;

         // zero results on a zero divisor, else saturate the temperature
         fault_ff <= f11_ff;
         if (f11_ff) begin
            temp_ff <= '0;
            pres_ff <= '0;
         end else begin
            pres_ff <= pfin;
            if (!tsh[31] && tsh[30:15] != 16'd0)
               temp_ff <= 16'h7FFF;
            else if (tsh[31] && tsh[30:15] != 16'hFFFF)
               temp_ff <= 16'h8000;
            else
               temp_ff <= tsh[15:0];
         end
      end
   end

endmodule

// ----- test/baro_pressure_temp_compensation_top_tb.sv -----
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation_top_tb
// Streams raw temperature/pressure requests through the compensation block
// under several calibration settings, with random sender gaps and receiver
// stalls; checks every response against an in-bench predictor or a set value.
// ----------------------------------------------------------------------------
module baro_pressure_temp_compensation_top_tb
   import bptc_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY = 75;

   typedef struct packed {
      logic        fault;
      logic [31:0] pressure;
      logic [15:0] temp;
   } comp_result_type;

   typedef struct {
      logic [15:0] ut;
      logic [23:0] up;
      logic        check;
      comp_result_type res;
   } stim_row_type;

   logic        clock, reset;
   logic        req_tvalid, req_tready;
   logic [39:0] req_tdata;
   logic        rsp_tvalid, rsp_tready;
   logic [47:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_psel, csr_penable, csr_pwrite;
   logic [4:0]  csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;
   logic        csr_pready;

   baro_pressure_temp_compensation_top DUT (.*);

   logic [31:0]     cal_regs [6];
   comp_result_type expected_q[$];
   int              mismatches;
   int              stall_mode;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("baro_pressure_temp_compensation_top_tb: errors");
      $finish;
   end

   function automatic logic [31:0] sra(logic [31:0] x, int n);
      return 32'($signed(x) >>> n);
   endfunction

   function automatic logic [31:0] sext(logic [15:0] x);
      return {{16{x[15]}}, x};
   endfunction

   function automatic comp_result_type compensate(logic [15:0] ut_in, logic [23:0] raw_p);
      comp_result_type r;
      logic [1:0]  oss;
      logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
      logic [31:0] ut, up, x1, x2, x3, b3, b4, b5, b6, b7, p, dv, sq;
      logic signed [63:0] q;
      int t;
      oss = cal_regs[REG_OVERSAMPLING][1:0];
      ac1 = sext(cal_regs[REG_CAL_AC1_AC2][31:16]);
      ac2 = sext(cal_regs[REG_CAL_AC1_AC2][15:0]);
      ac3 = sext(cal_regs[REG_CAL_AC3_AC4][31:16]);
      ac4 = {16'd0, cal_regs[REG_CAL_AC3_AC4][15:0]};
      ac5 = {16'd0, cal_regs[REG_CAL_AC5_AC6][31:16]};
      ac6 = {16'd0, cal_regs[REG_CAL_AC5_AC6][15:0]};
      b1  = sext(cal_regs[REG_CAL_B1_B2][31:16]);
      b2  = sext(cal_regs[REG_CAL_B1_B2][15:0]);
      mc  = sext(cal_regs[REG_CAL_MC_MD][31:16]);
      md  = sext(cal_regs[REG_CAL_MC_MD][15:0]);
      ut  = {16'd0, ut_in};
      up  = {8'd0, raw_p} >> (8 - oss);
      r   = '0;
      x1 = sra((ut - ac6) * ac5, 15);
      dv = x1 + md;
      if (dv == 0) begin
         r.fault = 1'b1;
         return r;
      end
      q  = 64'($signed(mc << 11)) / 64'($signed(dv));
      x2 = q[31:0];
      b5 = x1 + x2;
      b6 = b5 - 32'd4000;
      sq = sra(b6 * b6, 12);
      x1 = sra(b2 * sq, 11);
      x2 = sra(ac2 * b6, 11);
      x3 = x1 + x2;
      b3 = sra(((ac1 * 4 + x3) << oss) + 2, 2);
      x1 = sra(ac3 * b6, 13);
      x2 = sra(b1 * sq, 16);
      x3 = sra(x1 + x2 + 2, 2);
      b4 = (ac4 * (x3 + 32'd32768)) >> 15;
      if (b4 == 0) begin
         r.fault = 1'b1;
         return r;
      end
      b7 = (up - b3) * (32'd50000 >> oss);
      if (!b7[31]) p = (b7 * 2) / b4;
      else p = (b7 / b4) * 2;
      x1 = sra(p, 8) * sra(p, 8);
      x1 = sra(x1 * 32'd3038, 16);
      x2 = sra(p * (32'd0 - 32'd7357), 16);
      p  = p + sra(x1 + x2 + 32'd3791, 4);
      t = $signed(sra(b5 + 8, 4));
      if (t > 32767) t = 32767;
      if (t < -32768) t = -32768;
      r.temp     = t[15:0];
      r.pressure = p;
      return r;
   endfunction

   task automatic csr_write(reg_index_type idx, logic [31:0] val);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= 5'(idx) << 2;
      csr_pwdata  <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      cal_regs[idx] = (idx == REG_OVERSAMPLING) ? (val & 32'd3) : val;
      @(negedge clock);
   endtask

   // realistic calibration set with a chosen oversampling
   task automatic load_calibration(logic [1:0] oss);
      csr_write(REG_OVERSAMPLING, {30'd0, oss});
      csr_write(REG_CAL_AC1_AC2, {16'd408, -16'sd72});
      csr_write(REG_CAL_AC3_AC4, {-16'sd14383, 16'd32741});
      csr_write(REG_CAL_AC5_AC6, {16'd32757, 16'd23153});
      csr_write(REG_CAL_B1_B2, {16'd6190, 16'd4});
      csr_write(REG_CAL_MC_MD, {-16'sd8711, 16'd2868});
   endtask

   // hold valid after acceptance; drain drops it
   task automatic send(logic [15:0] ut, logic [23:0] up);
      req_tdata  <= {up, ut};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain;
      int guard;
      guard = 0;
      req_tvalid <= 1'b0;
      while (expected_q.size() != 0 && guard < 200000) begin
         @(negedge clock);
         guard++;
      end
      repeat (LATENCY + 10) @(negedge clock);
   endtask

   // keep valid high across a burst, drop it only in gaps
   task automatic random_burst(int count, bit realistic);
      int left, gap;
      logic [15:0] ut;
      logic [23:0] up;
      left = count;
      while (left > 0) begin
         for (int k = $urandom_range(1, 20); k > 0 && left > 0; k--) begin
            if (realistic) begin
               ut = 16'($urandom_range(20000, 36000));
               up = 24'($urandom_range(0, 24'hFFFFFF));
            end else begin
               ut = 16'($urandom);
               up = 24'($urandom);
            end
            req_tdata  <= {up, ut};
            req_tvalid <= 1'b1;
            expected_q.push_back(compensate(ut, up));
            @(posedge clock);
            while (!req_tready) @(posedge clock);
            @(negedge clock);
            left--;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   // receiver stall pattern: phases of free flow, light and heavy back-pressure
   always @(negedge clock) begin
      if (reset) rsp_tready <= 1'b1;
      else begin
         if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 3) != 0);
            default: rsp_tready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      comp_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tuser, rsp_tdata[47:16], rsp_tdata[15:0]};
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h", got);
         end else begin
            want = expected_q.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp t=%h p=%h f=%b got t=%h p=%h f=%b",
                     want.temp, want.pressure, want.fault,
                     got.temp, got.pressure, got.fault);
            end
         end
      end
   end

   stim_row_type directed[$];

   initial begin
      stim_row_type row;
      logic [15:0]  ext_ut [4];
      logic [23:0]  ext_up [4];
      mismatches  = 0;
      stall_mode  = 0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      rsp_tready  = 1'b1;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      foreach (cal_regs[i]) cal_regs[i] = '0;
      ext_ut[0] = 16'h0000; ext_up[0] = 24'h000000;
      ext_ut[1] = 16'hFFFF; ext_up[1] = 24'hFFFFFF;
      ext_ut[2] = 16'd27898; ext_up[2] = 24'h5D2300;
      ext_ut[3] = 16'h8000; ext_up[3] = 24'h800000;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // after reset every coefficient is zero: X1 + md is zero, so a fault
      directed.push_back('{16'h0000, 24'h000000, 1'b1, '{1'b1, 32'd0, 16'd0}});
      directed.push_back('{16'hFFFF, 24'hFFFFFF, 1'b1, '{1'b1, 32'd0, 16'd0}});
      foreach (directed[i]) begin
         expected_q.push_back(directed[i].check ? directed[i].res
                              : compensate(directed[i].ut, directed[i].up));
         send(directed[i].ut, directed[i].up);
      end
      drain();

      // md alone nonzero: ac4 zero gives B4 zero, the pressure divisor fault
      csr_write(REG_CAL_MC_MD, {16'd0, 16'd1});
      for (int i = 0; i < 3; i++) begin
         row = '{16'(i * 30000), 24'(i * 24'h7FFFFF), 1'b1, '{1'b1, 32'd0, 16'd0}};
         expected_q.push_back(row.res);
         send(row.ut, row.up);
      end
      drain();

      // typical calibration, all oversampling settings, extreme and mid fields
      for (int o = 0; o < 4; o++) begin
         load_calibration(2'(o));
         for (int j = 0; j < 4; j++) begin
            row.ut = ext_ut[j];
            row.up = ext_up[j];
            expected_q.push_back(compensate(row.ut, row.up));
            send(row.ut, row.up);
         end
         drain();
      end

      // random phases: realistic calibration and fully random registers
      for (int ph = 0; ph < 8; ph++) begin
         if (ph[0]) load_calibration(2'($urandom_range(0, 3)));
         else begin
            csr_write(REG_OVERSAMPLING, $urandom);
            csr_write(REG_CAL_AC1_AC2, $urandom);
            csr_write(REG_CAL_AC3_AC4, $urandom);
            csr_write(REG_CAL_AC5_AC6, $urandom);
            csr_write(REG_CAL_B1_B2, $urandom);
            csr_write(REG_CAL_MC_MD, (ph == 6) ? 32'hFFFF_FFFF : $urandom);
         end
         random_burst(210, ph[0] || ($urandom_range(0, 1) == 1));
         drain();
      end

      if (expected_q.size() != 0) mismatches++;
      if (mismatches == 0)
         $display("baro_pressure_temp_compensation_top_tb: clean");
      else
         $display("baro_pressure_temp_compensation_top_tb: errors");
      $finish;
   end

endmodule
